@@ rtl/core/nearest_scale_dim_pixel_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor scaler core
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SCALE_DIM_PIXEL_CORE_ASSERT_SVH
`define NEAREST_SCALE_DIM_PIXEL_CORE_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define NSDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never be true.
`define NSDP_ASSERT_NEVER(lbl, expr, msg) \
  `NSDP_ASSERT_IMP(lbl, 1'b1, !(expr), msg)

`endif

@@ rtl/core/nsdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsdp_pkg
// Widths, codes and pixel helper functions for the nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package nsdp_pkg;

  localparam int SRC_DEPTH   = 65536;
  localparam int ADDR_W      = $clog2(SRC_DEPTH);
  localparam int MAX_DST_DIM = 4096;

  localparam int SW_W       = 9;
  localparam int DW_W       = 13;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 32;
  localparam int FILL_W     = 24;
  localparam int IDX_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Scaled coordinate = (coord * src_size) / dst_size, done as long division.
  localparam int PROD_W = COORD_W + SW_W;
  localparam int QUO_W  = SW_W;
  localparam int GRP_W  = 3;
  localparam int NGRP   = QUO_W / GRP_W;
  localparam int LIN_W  = 2 * SW_W;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_FILL_COLOR,
    REG_DRAW_MODE
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_STATIC,
    MODE_ANIMATED,
    MODE_SOLID
  } draw_mode_e;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [GRP_W-1:0]  quo;
  } div_part_t;

  // Three restoring division steps producing quotient bits grp*3+2 .. grp*3.
  function automatic div_part_t div_group(input logic [PROD_W-1:0] rem,
                                          input logic [DW_W-1:0]   dvs,
                                          input int                grp);
    div_part_t           res;
    logic [PROD_W:0]     trial;
    logic [PROD_W-1:0]   r;
    int                  sh;
    r   = rem;
    res = '0;
    for (int k = 0; k < GRP_W; k++) begin
      sh    = grp * GRP_W + (GRP_W - 1 - k);
      trial = (PROD_W + 1)'(dvs) << sh;
      if ({1'b0, r} >= trial) begin
        r = r - trial[PROD_W-1:0];
        res.quo[GRP_W-1-k] = 1'b1;
      end
    end
    res.rem = r;
    return res;
  endfunction

  // c * 195 / 255, truncated; the divide by 255 is exact for every product of an 8-bit channel and 195.
  function automatic logic [7:0] dim_channel(input logic [7:0] c);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'd195;
    s = 17'(p) + 17'd1 + 17'(p >> 8);
    return s[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] dim_color(input logic [FILL_W-1:0] c);
    return {ALPHA_OPAQUE, dim_channel(c[23:16]), dim_channel(c[15:8]),
            dim_channel(c[7:0])};
  endfunction

endpackage

@@ rtl/core/nsdp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsdp channel interfaces
// Input, result and configuration channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nsdp_in_if;
  import nsdp_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [IDX_W-1:0]   store_index;
  logic [PIX_W-1:0]   write_pixel;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  modport source (output valid, action, store_index, write_pixel, dest_x, dest_y,
                  input ready);
  modport sink (input valid, action, store_index, write_pixel, dest_x, dest_y,
                output ready);
endinterface

interface nsdp_out_if;
  import nsdp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             out_of_range;
  modport source (output valid, out_pixel, out_of_range, input ready);
  modport sink (input valid, out_pixel, out_of_range, output ready);
endinterface

interface nsdp_cfg_if;
  import nsdp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/nsdp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsdp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nsdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/nearest_scale_dim_pixel_core.sv @@
`timescale 1ns / 1ps
`include "nearest_scale_dim_pixel_core_assert.svh"
// ----------------------------------------------------------------------------
// nearest_scale_dim_pixel_core
// Nearest-neighbor image scaler with a frame store and static, dimmed and
// solid-fill output modes.
// ----------------------------------------------------------------------------
// Usage: the cfg_i channel writes the six control registers (source width
// and height, destination width and height, fill color, draw mode); writes
// are always taken and should only be issued while no word is in flight.
// Each word on in_i is either a write, which loads one 32-bit pixel into the
// 64K-entry frame store and produces no result, or a read, which names a
// destination coordinate and produces exactly one word on out_o.
// Throughput is one word per clock while out_o is not stalled. A read word
// passes, in order, through the coordinate multiplies, the pipelined long
// division (three quotient bits per stage), the store address, the store's
// registered read port and the output register before it appears on out_o.
// Reset returns the registers to their defaults and empties the pipeline;
// the frame store itself is not cleared, and an entry must be written
// before it is read.
// When out_o is stalled, the pipeline keeps filling its empty stages and
// in_i.ready drops only once every stage holds a word.
// ----------------------------------------------------------------------------
module nearest_scale_dim_pixel_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  nsdp_cfg_if.sink    cfg_i,
  nsdp_in_if.sink     in_i,
  nsdp_out_if.source  out_o
);
  import nsdp_pkg::*;

  localparam int NSTG = 7;

  // Sideband that follows every word down to the store access.
  typedef struct packed {
    logic             is_read;
    logic             oor;
    logic [IDX_W-1:0] wr_idx;
    logic [PIX_W-1:0] wr_pix;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] num_x;
    logic [PROD_W-1:0] num_y;
  } mul_stage_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] rem_x;
    logic [PROD_W-1:0] rem_y;
    logic [QUO_W-1:0]  quo_x;
    logic [QUO_W-1:0]  quo_y;
  } div_stage_t;

  typedef struct packed {
    side_t             side;
    logic [ADDR_W-1:0] addr;
  } addr_stage_t;

  // Configuration registers.
  logic [SW_W-1:0]   src_width_q, src_height_q;
  logic [DW_W-1:0]   dst_width_q, dst_height_q;
  logic [FILL_W-1:0] fill_color_q;
  logic [MODE_W-1:0] draw_mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SW_W'(1);
      src_height_q <= SW_W'(1);
      dst_width_q  <= DW_W'(1);
      dst_height_q <= DW_W'(1);
      fill_color_q <= '0;
      draw_mode_q  <= MODE_SOLID;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SRC_WIDTH:  src_width_q  <= cfg_i.data[SW_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_i.data[SW_W-1:0];
        REG_DST_WIDTH:  dst_width_q  <= cfg_i.data[DW_W-1:0];
        REG_DST_HEIGHT: dst_height_q <= cfg_i.data[DW_W-1:0];
        REG_FILL_COLOR: fill_color_q <= cfg_i.data[FILL_W-1:0];
        REG_DRAW_MODE:  draw_mode_q  <= cfg_i.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Destination sizes beyond the supported bound act as the bound.
  logic [DW_W-1:0] dw_eff, dh_eff;
  assign dw_eff = (dst_width_q > DW_W'(MAX_DST_DIM)) ? DW_W'(MAX_DST_DIM) : dst_width_q;
  assign dh_eff = (dst_height_q > DW_W'(MAX_DST_DIM)) ? DW_W'(MAX_DST_DIM) : dst_height_q;

  // Stage valid bits and per-stage load enables. A stage loads whenever it
  // is empty or its contents move on, so bubbles collapse under a stall.
  logic [NSTG-1:0] v_q, v_d, en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  // Store access happens when a word moves from the address stage onward.
  logic              ram_we, ram_re;
  logic [PIX_W-1:0]  ram_rdata;
  addr_stage_t       addr_q, addr_d;

  assign ram_we = en[5] && v_q[4] && !addr_q.side.is_read &&
                  (32'(addr_q.side.wr_idx) < SRC_DEPTH);
  assign ram_re = en[5] && v_q[4] && addr_q.side.is_read;

  always_comb begin
    v_d = v_q;
    if (en[0]) v_d[0] = in_i.valid;
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) v_d[k] = v_q[k-1];
    end
    // Writes end at the store and produce no result.
    if (en[5]) v_d[5] = v_q[4] && addr_q.side.is_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Stage 1: range check and the two coordinate products.
  mul_stage_t mul_q, mul_d;

  always_comb begin
    mul_d.side.is_read = (in_i.action == ACT_READ);
    mul_d.side.oor     = (DW_W'(in_i.dest_x) >= dw_eff) || (DW_W'(in_i.dest_y) >= dh_eff);
    mul_d.side.wr_idx  = in_i.store_index;
    mul_d.side.wr_pix  = in_i.write_pixel;
    mul_d.num_x        = PROD_W'(in_i.dest_x) * PROD_W'(src_width_q);
    mul_d.num_y        = PROD_W'(in_i.dest_y) * PROD_W'(src_height_q);
  end

  // Stages 2 to 4: long division, one group of quotient bits per stage,
  // most significant group first.
  div_stage_t div_q [NGRP];
  div_stage_t div_d [NGRP];

  always_comb begin
    div_part_t  px, py;
    div_stage_t prev;
    for (int k = 0; k < NGRP; k++) begin
      if (k == 0) begin
        prev       = '0;
        prev.side  = mul_q.side;
        prev.rem_x = mul_q.num_x;
        prev.rem_y = mul_q.num_y;
      end else begin
        prev = div_q[k-1];
      end
      px = div_group(prev.rem_x, dw_eff, NGRP - 1 - k);
      py = div_group(prev.rem_y, dh_eff, NGRP - 1 - k);
      div_d[k]       = prev;
      div_d[k].rem_x = px.rem;
      div_d[k].rem_y = py.rem;
      div_d[k].quo_x[(NGRP-1-k)*GRP_W +: GRP_W] = px.quo;
      div_d[k].quo_y[(NGRP-1-k)*GRP_W +: GRP_W] = py.quo;
    end
  end

  // Stage 5: linear store address, wrapped to the store size.
  logic [LIN_W-1:0] lin_addr;

  always_comb begin
    lin_addr = LIN_W'(div_q[NGRP-1].quo_y) * LIN_W'(src_width_q) +
               LIN_W'(div_q[NGRP-1].quo_x);
    addr_d.side = div_q[NGRP-1].side;
    addr_d.addr = lin_addr[ADDR_W-1:0];
  end

  // Stage 6: store read data lives in the RAM output register.
  logic rd_oor_q;

  nsdp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SRC_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q.side.wr_idx[ADDR_W-1:0]),
    .wdata_i (addr_q.side.wr_pix),
    .re_i    (ram_re),
    .raddr_i (addr_q.addr),
    .rdata_o (ram_rdata)
  );

  // Stage 7: pixel formatting into the output register.
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             oor_q;

  always_comb begin
    case (draw_mode_q)
      MODE_STATIC:   pix_d = {ALPHA_OPAQUE, ram_rdata[FILL_W-1:0]};
      MODE_ANIMATED: pix_d = (ram_rdata[PIX_W-1:FILL_W] != '0) ?
                             dim_color(ram_rdata[FILL_W-1:0]) : dim_color(fill_color_q);
      default:       pix_d = {ALPHA_OPAQUE, fill_color_q};
    endcase
    if (rd_oor_q) pix_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) mul_q <= mul_d;
    for (int k = 0; k < NGRP; k++) begin
      if (en[k+1]) div_q[k] <= div_d[k];
    end
    if (en[4]) addr_q <= addr_d;
    if (en[5]) rd_oor_q <= addr_q.side.oor;
    if (en[6]) begin
      pix_q <= pix_d;
      oor_q <= rd_oor_q;
    end
  end

  assign out_o.valid        = v_q[NSTG-1];
  assign out_o.out_pixel    = pix_q;
  assign out_o.out_of_range = oor_q;

  `NSDP_ASSERT_IMP(a_oor_zero, out_o.valid && out_o.out_of_range,
                   out_o.out_pixel == '0, "out-of-range word carries a nonzero pixel")
  `NSDP_ASSERT_IMP(a_alpha_opaque, out_o.valid && !out_o.out_of_range,
                   out_o.out_pixel[PIX_W-1:FILL_W] == ALPHA_OPAQUE,
                   "in-range word is not opaque")
  `NSDP_ASSERT_IMP(a_full_on_backpressure, !in_i.ready, (&v_q) && !out_o.ready,
                   "input stalled while a stage is empty")
  `NSDP_ASSERT_NEVER(a_ram_rw_excl, ram_we && ram_re,
                     "frame store written and read by one word")

endmodule
